// ===== sv/mtf_pkg.sv =====
package mtf_pkg;

    // Filter dimensions
    localparam int CHANNELS  = 2;
    localparam int ORDER     = 6;
    localparam int NUM_COEFS = 7;
    localparam int ROW_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Pipeline depth of the top level
    localparam int NSTG = 6;

    // Datapath widths
    localparam int SMP_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int CFG_IDX_W = 3;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd7;

    // Reset values
    localparam logic signed [SMP_W-1:0] COEF0_RESET = 16'sd16384;
    localparam logic signed [SMP_W-1:0] GAIN_RESET  = 16'sd4096;

    typedef logic signed [SMP_W-1:0]  sample_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [ROW_W-1:0]         row_t;

    // Rounded and clipped value with its clip flag
    typedef struct packed {
        logic    clip;
        sample_t val;
    } sat_t;

    // Control from the top level to every tap cell
    typedef struct packed {
        logic ld_prod;
        logic commit;
        row_t row;
    } tap_ctrl_t;

    // Channel tag to delay row; tags past the last channel use the last row
    function automatic row_t row_of(input logic ch);
        row_t r;
        if (int'(ch) >= CHANNELS)
            r = ROW_W'(CHANNELS - 1);
        else
            r = ROW_W'(ch);
        return r;
    endfunction

    // Q5.27 -> Q1.15, round half up, saturate
    function automatic sat_t round_sat_gain(input prod_t p);
        logic signed [PROD_W:0]    s;
        logic signed [PROD_W-12:0] r;
        sat_t res;
        s = $signed({p[PROD_W-1], p}) + 33'sd2048;
        r = s[PROD_W:12];
        if (r > 21'sd32767) begin
            res.clip = 1'b1;
            res.val  = 16'sd32767;
        end else if (r < -21'sd32768) begin
            res.clip = 1'b1;
            res.val  = -16'sd32768;
        end else begin
            res.clip = 1'b0;
            res.val  = r[SMP_W-1:0];
        end
        return res;
    endfunction

    // Q11.29 -> Q1.15, round half up, saturate
    function automatic sat_t round_sat_acc(input acc_t a);
        logic signed [ACC_W:0]    s;
        logic signed [ACC_W-14:0] r;
        sat_t res;
        s = $signed({a[ACC_W-1], a}) + 41'sd8192;
        r = s[ACC_W:14];
        if (r > 27'sd32767) begin
            res.clip = 1'b1;
            res.val  = 16'sd32767;
        end else if (r < -27'sd32768) begin
            res.clip = 1'b1;
            res.val  = -16'sd32768;
        end else begin
            res.clip = 1'b0;
            res.val  = r[SMP_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/fir_in_if.sv =====
interface fir_in_if import mtf_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    channel;
    sample_t sample_in;

    modport source (output valid, output channel, output sample_in, input ready);
    modport sink   (input valid, input channel, input sample_in, output ready);
endinterface

// ===== sv/fir_out_if.sv =====
interface fir_out_if import mtf_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    channel_out;
    sample_t sample_out;
    logic    saturated;

    modport source (output valid, output channel_out, output sample_out, output saturated,
                    input ready);
    modport sink   (input valid, input channel_out, input sample_out, input saturated,
                    output ready);
endinterface

// ===== sv/mtf_tap_cell.sv =====
module mtf_tap_cell import mtf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tap_ctrl_t ctrl,
    input  sample_t   x,
    input  sample_t   coef,
    input  acc_t      z_in,
    output acc_t      z_out
);

    prod_t prod_reg;
    prod_t prod_next;
    acc_t  z_reg [CHANNELS];
    acc_t  z_next;

    // Tap product, one per item
    assign prod_next = PROD_W'(x * coef);

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    // Partial sum from the neighbor plus this tap
    assign z_next = ACC_W'(prod_reg) + z_in;
    assign z_out  = z_reg[ctrl.row];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                z_reg[c] <= '0;
            end
        end
        else if (ctrl.commit)
        begin
            z_reg[ctrl.row] <= z_next;
        end
    end

endmodule

// ===== sv/multichannel_transposed_fir.sv =====
// Multichannel transposed-form FIR filter, 7 taps, 2 channels.
// Input channel din: one item is a channel tag and a signed Q1.15 sample.
// Output channel dout: the channel tag, the filtered Q1.15 sample and a flag
// set when the gain stage or the output was clipped. Both use valid/ready.
// Configuration: cfg_we/cfg_index/cfg_data write coef_0..coef_6 (index 0..6,
// Q2.14) and input_gain (index 7, Q4.12). Write only while the block is idle.
// Pipeline: an item passes six registers (input register, gain multiply, gain
// rounding, tap multiplies, tap update, output rounding) from input accept to
// output valid.
// Throughput: one item per cycle unless stalled. The tap cells update all
// partial sums of the item's row at once, so items of the same channel can
// follow each other back to back.
// Reset: coefficients return to a single unity tap, gain to 1.0, all partial
// sums clear to zero and the pipeline empties.
// Stall: every stage holds its item while the next is stalled, so bubbles
// are squeezed out; input ready falls only once all six stages hold items.
module multichannel_transposed_fir import mtf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SMP_W-1:0]     cfg_data,
    fir_in_if.sink               din,
    fir_out_if.source            dout
);

    // Configuration registers
    sample_t coef_reg [NUM_COEFS];
    sample_t gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
            coef_reg[0] <= COEF0_RESET;
            gain_reg    <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GAIN)
            begin
                gain_reg <= cfg_data;
            end
            else
            begin
                coef_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Stage valids and per-stage load enables
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] v_in;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || dout.ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_in = {v_reg[NSTG-2:0], din.valid};
        for (int k = 0; k < NSTG; k++)
        begin
            v_next[k] = en[k] ? v_in[k] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign din.ready = en[0];

    // Stage payloads
    logic    ch0_reg, ch1_reg, ch2_reg, ch3_reg, ch4_reg, ch5_reg;
    sample_t smp0_reg;
    prod_t   gp1_reg;
    prod_t   gp1_next;
    sample_t x2_reg;
    logic    clip2_reg, clip3_reg, clip4_reg, clip5_reg;
    prod_t   p0_reg;
    prod_t   p0_next;
    acc_t    acc4_reg;
    sample_t y5_reg;
    sat_t    gain_sat;
    sat_t    out_sat;
    acc_t    z_first;

    assign gp1_next = PROD_W'(smp0_reg * gain_reg);
    assign gain_sat = round_sat_gain(gp1_reg);
    assign p0_next  = PROD_W'(x2_reg * coef_reg[0]);
    assign out_sat  = round_sat_acc(acc4_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ch0_reg  <= din.channel;
            smp0_reg <= din.sample_in;
        end
        if (en[1])
        begin
            ch1_reg <= ch0_reg;
            gp1_reg <= gp1_next;
        end
        if (en[2])
        begin
            ch2_reg   <= ch1_reg;
            x2_reg    <= gain_sat.val;
            clip2_reg <= gain_sat.clip;
        end
        if (en[3])
        begin
            ch3_reg   <= ch2_reg;
            clip3_reg <= clip2_reg;
            p0_reg    <= p0_next;
        end
        if (en[4])
        begin
            ch4_reg   <= ch3_reg;
            clip4_reg <= clip3_reg;
            acc4_reg  <= ACC_W'(p0_reg) + z_first;
        end
        if (en[5])
        begin
            ch5_reg   <= ch4_reg;
            y5_reg    <= out_sat.val;
            clip5_reg <= clip4_reg | out_sat.clip;
        end
    end

    // Tap cells: cell k holds partial sum k of every channel
    tap_ctrl_t ctrl;
    acc_t      z_chain [ORDER+1];

    assign ctrl.ld_prod = en[3];
    assign ctrl.commit  = v_reg[3] && en[4];
    assign ctrl.row     = row_of(ch3_reg);
    assign z_chain[ORDER] = '0;
    assign z_first        = z_chain[0];

    for (genvar k = 0; k < ORDER; k++)
    begin : g_cell
        mtf_tap_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .x     (x2_reg),
            .coef  (coef_reg[k+1]),
            .z_in  (z_chain[k+1]),
            .z_out (z_chain[k])
        );
    end

    // Output register
    assign dout.valid       = v_reg[NSTG-1];
    assign dout.channel_out = ch5_reg;
    assign dout.sample_out  = y5_reg;
    assign dout.saturated   = clip5_reg;

endmodule

// ===== sv/mtf_checker.sv =====
module mtf_checker import mtf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input logic    channel_out,
    input sample_t sample_out,
    input logic    saturated
);

    // Items accepted but not yet delivered
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
            cnt_next = cnt_reg + 3'd1;
        else if (!in_acc && out_acc)
            cnt_next = cnt_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
        $stable(sample_out) && $stable(channel_out) && $stable(saturated))
        else $error("stalled result changed");

    // With an empty output register the pipeline must take items
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Never more items in flight than pipeline stages; no result from nothing
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= 3'(NSTG)) && (!out_valid || cnt_reg != 3'd0))
        else $error("item count out of range");

endmodule

bind multichannel_transposed_fir mtf_checker u_mtf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (din.valid),
    .in_ready    (din.ready),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .channel_out (dout.channel_out),
    .sample_out  (dout.sample_out),
    .saturated   (dout.saturated)
);

// ===== tb/testbench.sv =====
module testbench;
    import mtf_pkg::*;

    // Coefficient register indexes; the gain register index comes from the package
    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_0, COEF_1, COEF_2, COEF_3, COEF_4, COEF_5, COEF_6
    } coef_reg_e;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // One directed step: either a register write or a sample item
    typedef struct {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic                 ch;
        sample_t              val;
        bit                   typed;
        sample_t              want;
        logic                 want_clip;
    } script_row_t;

    typedef struct packed {
        logic    ch;
        sample_t smp;
        logic    clip;
    } fir_out_t;

    localparam int GAIN_FRAC    = 12;
    localparam int ACC_FRAC     = 14;
    localparam int ITEM_TOTAL   = 1150;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SCRIPT_LEN   = 36;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SMP_W-1:0]     cfg_data;

    fir_in_if  din ();
    fir_out_if dout ();

    multichannel_transposed_fir DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .din       (din),
        .dout      (dout)
    );

    // Filter state mirrored by the testbench
    sample_t coef_reg [NUM_COEFS];
    sample_t gain_reg;
    longint  taps [CHANNELS][ORDER];

    fir_out_t filtered_q [$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  clip_count = 0;
    int  settings_loaded = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    int  roll;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    // Directed steps; expected values typed in where they are obvious
    script_row_t script [SCRIPT_LEN] = '{
        // reset setting passes samples through unchanged
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd0,      1'b1, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd32767,  1'b1, 16'sd32767,  1'b0},
        '{ROW_ITEM, COEF_0, 1'b1, -16'sd32768, 1'b1, -16'sd32768, 1'b0},
        '{ROW_ITEM, COEF_0, 1'b1, 16'sd1,      1'b1, 16'sd1,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, -16'sd1,     1'b1, -16'sd1,     1'b0},
        // gain 0.5: gain rounding is half up
        '{ROW_CFG,  REG_GAIN, 1'b0, 16'sd2048, 1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd1,      1'b1, 16'sd1,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b1, -16'sd1,     1'b1, 16'sd0,      1'b0},
        // largest gain clips the scaled sample
        '{ROW_CFG,  REG_GAIN, 1'b0, 16'sd32767, 1'b0, 16'sd0,     1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd32767,  1'b1, 16'sd32767,  1'b1},
        '{ROW_ITEM, COEF_0, 1'b1, -16'sd32768, 1'b1, -16'sd32768, 1'b1},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd0,      1'b1, 16'sd0,      1'b0},
        // most negative gain
        '{ROW_CFG,  REG_GAIN, 1'b0, -16'sd32768, 1'b0, 16'sd0,    1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, -16'sd32768, 1'b1, 16'sd32767,  1'b1},
        '{ROW_ITEM, COEF_0, 1'b1, 16'sd1,      1'b0, 16'sd0,      1'b0},
        // unity gain, tap 0 at 0.5: output rounding is half up
        '{ROW_CFG,  REG_GAIN, 1'b0, 16'sd4096, 1'b0, 16'sd0,      1'b0},
        '{ROW_CFG,  COEF_0, 1'b0, 16'sd8192,   1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd1,      1'b1, 16'sd1,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, -16'sd1,     1'b1, 16'sd0,      1'b0},
        // all taps at their extremes, alternating sign
        '{ROW_CFG,  COEF_0, 1'b0, -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{ROW_CFG,  COEF_1, 1'b0, 16'sd32767,  1'b0, 16'sd0,      1'b0},
        '{ROW_CFG,  COEF_2, 1'b0, -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{ROW_CFG,  COEF_3, 1'b0, 16'sd32767,  1'b0, 16'sd0,      1'b0},
        '{ROW_CFG,  COEF_4, 1'b0, -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{ROW_CFG,  COEF_5, 1'b0, 16'sd32767,  1'b0, 16'sd0,      1'b0},
        '{ROW_CFG,  COEF_6, 1'b0, -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd32767,  1'b1, -16'sd32768, 1'b1},
        '{ROW_ITEM, COEF_0, 1'b0, -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd0,      1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd0,      1'b0, 16'sd0,      1'b0},
        // channel 1 row is still empty
        '{ROW_ITEM, COEF_0, 1'b1, 16'sd32767,  1'b1, -16'sd32768, 1'b1},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd0,      1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd0,      1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd0,      1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b1, -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{ROW_ITEM, COEF_0, 1'b0, 16'sd0,      1'b0, 16'sd0,      1'b0}
    };

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Clip to the 16-bit range, flagging when it bites
    function automatic longint clip16(input longint v, inout bit clip);
        if (v > 32767)
        begin
            clip = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            clip = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // One filter step: gain, tap 0 plus first partial sum, then shift the row
    function automatic fir_out_t run_filter(input logic ch, input sample_t s);
        fir_out_t res;
        int       row;
        bit       clip;
        longint   x;
        longint   y;
        clip = 1'b0;
        row  = (int'(ch) >= CHANNELS) ? CHANNELS - 1 : int'(ch);
        x = clip16((longint'(s) * longint'(gain_reg) + (longint'(1) << (GAIN_FRAC - 1)))
                   >>> GAIN_FRAC, clip);
        y = clip16((longint'(coef_reg[0]) * x + taps[row][0]
                   + (longint'(1) << (ACC_FRAC - 1))) >>> ACC_FRAC, clip);
        for (int j = 1; j < ORDER; j++)
            taps[row][j-1] = longint'(coef_reg[j]) * x + taps[row][j];
        taps[row][ORDER-1] = longint'(coef_reg[ORDER]) * x;
        res.ch   = ch;
        res.smp  = sample_t'(y);
        res.clip = clip;
        clip_count += clip;
        return res;
    endfunction

    // Sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (tx_steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 16'sd32767;
        if (r < 8)
            return -16'sd32768;
        if (r < 10)
            return 16'sd0;
        if (r < 25)
            return sample_t'($urandom_range(0, 127) - 64);
        return sample_t'($urandom);
    endfunction

    // Register value: extremes in the first settings, then a mix
    function automatic sample_t pick_reg(input int phase, input int span);
        int r;
        if (phase == 0)
            return 16'sd32767;
        if (phase == 1)
            return -16'sd32768;
        r = $urandom_range(99);
        if (r < 6)
            return 16'sd32767;
        if (r < 12)
            return -16'sd32768;
        if (r < 20)
            return 16'sd0;
        return sample_t'($urandom_range(0, 2 * span) - span);
    endfunction

    // Register write; the caller drops the write enable after the last one
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input sample_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_GAIN)
            gain_reg = value;
        else
            coef_reg[idx] = value;
    endtask

    // Present one item and hold it until accepted
    task automatic send_item(input logic ch, input sample_t s, input bit typed,
                             input fir_out_t typed_res);
        fir_out_t res;
        int       gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid     <= 1'b1;
        din.channel   <= ch;
        din.sample_in <= s;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        res = run_filter(ch, s);
        filtered_q.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle();
        din.valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random back-pressure and comparison
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dout.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (dout.valid && dout.ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("unexpected output item: channel_out=%0d sample_out=%0d saturated=%0d",
                           dout.channel_out, dout.sample_out, dout.saturated);
                    mismatches++;
                end
                else
                begin
                    fir_out_t want;
                    want = filtered_q.pop_front();
                    if (dout.channel_out !== want.ch)
                    begin
                        $error("channel_out: expected %0d, got %0d", want.ch, dout.channel_out);
                        mismatches++;
                    end
                    if (dout.sample_out !== want.smp)
                    begin
                        $error("sample_out: expected %0d, got %0d", want.smp, dout.sample_out);
                        mismatches++;
                    end
                    if (dout.saturated !== want.clip)
                    begin
                        $error("saturated: expected %0d, got %0d", want.clip, dout.saturated);
                        mismatches++;
                    end
                end
            end
            // pick next cycle's ready
            if (rx_steady)
                dout.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                dout.ready <= 1'b0;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 65)
                    dout.ready <= 1'b1;
                else
                begin
                    stall_left = (roll < 94) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                    dout.ready <= 1'b0;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int       phase;
        int       burst;
        int       fixed_ch;
        bit [7:0] mask;
        fir_out_t typed_res;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        din.valid     = 1'b0;
        din.channel   = 1'b0;
        din.sample_in = '0;
        dout.ready    = 1'b0;

        // mirror of the reset state
        foreach (coef_reg[k])
            coef_reg[k] = '0;
        coef_reg[0] = COEF0_RESET;
        gain_reg    = GAIN_RESET;
        foreach (taps[c, k])
            taps[c][k] = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed steps
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (script[i].kind == ROW_CFG)
            begin
                if (i == 0 || script[i-1].kind != ROW_CFG)
                    settle();
                reg_write(script[i].idx, script[i].val);
                settings_loaded++;
                if (i + 1 == SCRIPT_LEN || script[i+1].kind != ROW_CFG)
                    cfg_we <= 1'b0;
            end
            else
            begin
                typed_res = '{ch: script[i].ch, smp: script[i].want,
                              clip: script[i].want_clip};
                send_item(script[i].ch, script[i].val, script[i].typed, typed_res);
            end
        end

        // random phases, each with a fresh register setting, up to the item total
        phase = 0;
        while (items_sent < ITEM_TOTAL)
        begin
            settle();
            mask = (phase < 2 || phase % 3 == 0) ? 8'hFF : 8'($urandom_range(1, 255));
            for (int k = 0; k < NUM_COEFS; k++)
                if (mask[k])
                    reg_write(CFG_IDX_W'(COEF_0 + k), pick_reg(phase, 8192));
            if (mask[REG_GAIN])
                reg_write(REG_GAIN, pick_reg(phase, 8192));
            cfg_we <= 1'b0;
            settings_loaded++;

            tx_steady = (phase % 5 == 2);
            rx_steady = (phase % 5 == 2) || (phase % 7 == 4);
            fixed_ch  = $urandom_range(1);
            burst     = $urandom_range(80, 110);
            for (int n = 0; n < burst && items_sent < ITEM_TOTAL; n++)
            begin
                typed_res = '0;
                send_item((phase % 4 == 3) ? 1'(fixed_ch) : 1'($urandom_range(1)),
                          pick_sample(), 1'b0, typed_res);
            end
            phase++;
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Filtered %0d samples on both channels over %0d register settings.",
                 items_sent, settings_loaded);
        $display("%0d results were expected to clip, %0d mismatches seen.",
                 clip_count, mismatches);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== multichannel_transposed_fir.f =====
sv/mtf_pkg.sv
sv/fir_in_if.sv
sv/fir_out_if.sv
sv/mtf_tap_cell.sv
sv/multichannel_transposed_fir.sv
sv/mtf_checker.sv
tb/testbench.sv
